// ===== rtl/kfmm_pkg.sv =====
// Shared types and constants for the key frequency min/max tracker.
`timescale 1ns / 1ps

package kfmm_pkg;

   // Fixed width of the key fields on the ports.
   localparam int KEY_W = 6;

   // Default sizing of the count table.
   localparam int KEYS_DEF       = 64;
   localparam int COUNT_BITS_DEF = 16;

   // Request action codes.
   localparam logic ACT_INC = 1'b0;
   localparam logic ACT_DEC = 1'b1;

   typedef struct packed {
      logic             action;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0] max_key;
      logic [KEY_W-1:0] min_key;
      logic             any_present;
      logic             underflow;
      logic             saturated;
   } rsp_type;

   // Travels alongside the memory read data during a scan.
   typedef struct packed {
      logic valid;
      logic first;
   } scan_tag_type;

endpackage

// ===== rtl/kfmm_count_mem.sv =====
// Count table storage: one write port and one registered read port.
`timescale 1ns / 1ps

module kfmm_count_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/kfmm_scan.sv =====
// Running maximum and minimum over the counts streamed out of the table.
`timescale 1ns / 1ps

module kfmm_scan #(
   parameter int IDX_W = 6,
   parameter int COUNT_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  kfmm_pkg::scan_tag_type  tag,
   input  logic [IDX_W-1:0]        tag_idx,
   input  logic [COUNT_BITS-1:0]   count,
   output logic                    found,
   output logic [IDX_W-1:0]        max_idx,
   output logic [IDX_W-1:0]        min_idx
);

   import kfmm_pkg::*;

   logic                  found_ff, found_in;
   logic [COUNT_BITS-1:0] max_c_ff, max_c_in, min_c_ff, min_c_in;
   logic [IDX_W-1:0]      max_k_ff, max_k_in, min_k_ff, min_k_in;

   logic                  base_found;
   logic [COUNT_BITS-1:0] base_max_c, base_min_c;
   logic [IDX_W-1:0]      base_max_k, base_min_k;

   // The first element of a scan starts from an empty table.
   always_comb begin
      base_found = tag.first ? 1'b0 : found_ff;
      base_max_c = tag.first ? '0 : max_c_ff;
      base_min_c = tag.first ? '0 : min_c_ff;
      base_max_k = tag.first ? '0 : max_k_ff;
      base_min_k = tag.first ? '0 : min_k_ff;

      found_in = base_found;
      max_c_in = base_max_c;
      min_c_in = base_min_c;
      max_k_in = base_max_k;
      min_k_in = base_min_k;

      // A zero count marks an absent key and is skipped.
      if (count != '0) begin
         if (!base_found) begin
            found_in = 1'b1;
            max_c_in = count;
            min_c_in = count;
            max_k_in = tag_idx;
            min_k_in = tag_idx;
         end else begin
            // Equal counts move the maximum up to the higher index.
            if (count >= base_max_c) begin
               max_c_in = count;
               max_k_in = tag_idx;
            end
            if (count < base_min_c) begin
               min_c_in = count;
               min_k_in = tag_idx;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (tag.valid) begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tag.valid) begin
         max_c_ff <= max_c_in;
         min_c_ff <= min_c_in;
         max_k_ff <= max_k_in;
         min_k_ff <= min_k_in;
      end
   end

   assign found   = found_ff;
   assign max_idx = max_k_ff;
   assign min_idx = min_k_ff;

endmodule

// ===== rtl/key_frequency_min_max_tracker_unit.sv =====
// Top level of the key frequency tracker: sequencer, count table and scan unit.
//
// The block keeps one saturating count per key in a synchronous memory and,
// for every request, increments or decrements one key's count and then
// reports the key with the largest nonzero count (highest index on ties),
// the key with the smallest nonzero count (lowest index on ties), whether any
// key is present, and whether the update underflowed or saturated. After
// reset the block first runs a clearing pass that writes zero to every table
// entry; req_ready stays low until it finishes. Each request then occupies
// the block from the cycle in which it is accepted until its response is
// loaded: the key's count is read, the new count is written back, every
// entry streams through the single read port of the table, the last read
// arrives, and the response register is loaded once it is free. The scan
// through the table read port takes most of that time. One request is in
// flight at a time; because accesses never overlap, the scan always sees the
// freshly written count. The response register lets the next request be
// accepted while the previous response still waits on rsp_ready. A key index
// at or beyond KEYS leaves the table untouched and raises no flag, and
// reported key indices are truncated to the port width.
`timescale 1ns / 1ps

module key_frequency_min_max_tracker_unit #(
   parameter int KEYS = kfmm_pkg::KEYS_DEF,
   parameter int COUNT_BITS = kfmm_pkg::COUNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  kfmm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output kfmm_pkg::rsp_type rsp_data
);

   import kfmm_pkg::*;

   localparam int IDX_W = $clog2(KEYS);
   // Wide enough to hold both a key and the value KEYS itself.
   localparam int CMP_W = ((IDX_W > KEY_W) ? IDX_W : KEY_W) + 1;

   // Sequencer states.
   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_UPDATE = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_WAIT   = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0] state_ff, state_in;

   // Shared index counter: entry being cleared or entry being scanned.
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             idx_last;

   // Latched request.
   logic             act_ff;
   logic             in_range_ff;
   logic [IDX_W-1:0] addr_ff;

   // Flags of the update, held until the response is loaded.
   logic underflow_ff, underflow_in;
   logic saturated_ff, saturated_in;

   // Read data tag, aligned with the memory's registered read.
   scan_tag_type     tag_ff, tag_in;
   logic [IDX_W-1:0] tag_idx_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic                  req_fire;
   logic                  rsp_load;
   logic [CMP_W-1:0]      key_ext;
   logic                  key_in_range;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [COUNT_BITS-1:0] wr_data;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [COUNT_BITS-1:0] rd_data;

   logic                  cnt_full, cnt_empty;
   logic                  upd_blocked;
   logic [COUNT_BITS-1:0] cnt_next;

   logic                  scan_found;
   logic [IDX_W-1:0]      scan_max, scan_min;

   assign req_ready    = (state_ff == ST_IDLE);
   assign req_fire     = req_valid && req_ready;
   assign key_ext      = CMP_W'(req_data.key);
   assign key_in_range = (key_ext < CMP_W'(KEYS));
   assign idx_last     = (idx_ff == IDX_W'(KEYS - 1));

   // The response register is free when empty or being drained this cycle.
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Read-modify-write arithmetic on the count fetched in the update cycle.
   assign cnt_full  = (rd_data == {COUNT_BITS{1'b1}});
   assign cnt_empty = (rd_data == '0);
   always_comb begin
      if (act_ff == ACT_INC) begin
         cnt_next     = rd_data + COUNT_BITS'(1);
         saturated_in = in_range_ff && cnt_full;
         underflow_in = 1'b0;
      end else begin
         cnt_next     = rd_data - COUNT_BITS'(1);
         saturated_in = 1'b0;
         underflow_in = in_range_ff && cnt_empty;
      end
   end
   assign upd_blocked = saturated_in || underflow_in;

   // Memory port steering.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = '0;
      rd_en   = 1'b0;
      rd_addr = idx_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
         end
         ST_IDLE: begin
            rd_en   = req_fire;
            rd_addr = key_ext[IDX_W-1:0];
         end
         ST_UPDATE: begin
            wr_en   = in_range_ff && !upd_blocked;
            wr_addr = addr_ff;
            wr_data = cnt_next;
         end
         ST_SCAN: begin
            rd_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            idx_in = idx_ff + IDX_W'(1);
            if (idx_last) begin
               state_in = ST_IDLE;
               idx_in   = '0;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_SCAN;
            idx_in   = '0;
         end
         ST_SCAN: begin
            idx_in = idx_ff + IDX_W'(1);
            if (idx_last) begin
               state_in = ST_WAIT;
               idx_in   = '0;
            end
         end
         ST_WAIT: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            idx_in   = '0;
         end
      endcase
   end

   always_comb begin
      tag_in.valid = (state_ff == ST_SCAN);
      tag_in.first = (idx_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         tag_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         tag_ff   <= tag_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      tag_idx_ff <= idx_ff;
      if (req_fire) begin
         act_ff      <= req_data.action;
         in_range_ff <= key_in_range;
         addr_ff     <= key_ext[IDX_W-1:0];
      end
      if (state_ff == ST_UPDATE) begin
         underflow_ff <= underflow_in;
         saturated_ff <= saturated_in;
      end
      if (rsp_load) begin
         rsp_data_ff.max_key     <= KEY_W'(scan_max);
         rsp_data_ff.min_key     <= KEY_W'(scan_min);
         rsp_data_ff.any_present <= scan_found;
         rsp_data_ff.underflow   <= underflow_ff;
         rsp_data_ff.saturated   <= saturated_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   kfmm_count_mem #(
      .DEPTH (KEYS),
      .WIDTH (COUNT_BITS),
      .ADDR_W(IDX_W)
   ) u_mem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   kfmm_scan #(
      .IDX_W     (IDX_W),
      .COUNT_BITS(COUNT_BITS)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .tag    (tag_ff),
      .tag_idx(tag_idx_ff),
      .count  (rd_data),
      .found  (scan_found),
      .max_idx(scan_max),
      .min_idx(scan_min)
   );

endmodule

// ===== rtl/kfmm_checker.sv =====
// Port-level checks for the key frequency tracker, bound to the top level.
`timescale 1ns / 1ps

module kfmm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input kfmm_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input kfmm_pkg::rsp_type rsp_data
);

   import kfmm_pkg::*;

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // An empty table reports both keys as zero.
   a_empty_keys: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.any_present |->
         rsp_data.max_key == '0 && rsp_data.min_key == '0)
      else $error("empty table reported a nonzero key");

   // One update cannot both underflow and saturate.
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.underflow && rsp_data.saturated))
      else $error("underflow and saturated both set");

   // Only one request is in flight: acceptance closes the input side.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request accepted back to back");

endmodule

bind key_frequency_min_max_tracker_unit kfmm_checker u_kfmm_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

// ===== dv/key_frequency_min_max_tracker_unit_tb.sv =====
// Self-checking testbench for the key frequency min/max tracker unit.
`timescale 1ns / 1ps

module key_frequency_min_max_tracker_unit_tb;
   import kfmm_pkg::*;

   // The block runs at its default sizing, which covers every key the
   // request field can name.
   localparam int KEYS       = KEYS_DEF;
   localparam int COUNT_BITS = COUNT_BITS_DEF;

   localparam int CLK_PERIOD   = 8;
   localparam int RESET_CYCLES = 9;

   // Random request count, the quiet tail at the end of the run, the item at
   // which the long response hold-off starts, and how long that hold lasts.
   localparam int RANDOM_ITEMS = 1400;
   localparam int QUIET_TAIL   = 200;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 400;

   // The limit allows for each request's time inside the block, a sender gap
   // and a receiver stall on every request, the clearing pass after reset and
   // the long hold-off, then triples the total.
   localparam int CYCLE_LIMIT = 3 * ((RANDOM_ITEMS + 30) * (KEYS + 4 + 8)
                                     + KEYS + HOLD_CYCLES + RESET_CYCLES);

   localparam int MAX_REPORTS = 10;

   typedef logic [COUNT_BITS-1:0] tally_type;

   // One row of the directed stimulus table. When typed is set, the expected
   // response is the one written in the row and not the predicted one.
   typedef struct packed {
      req_type req;
      logic    typed;
      rsp_type rsp;
   } probe_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Mirror of the count table and the responses still owed by the block.
   tally_type tally [KEYS];
   rsp_type   pending_reports [$];

   int  fault_count = 0;
   int  cycle_count = 0;
   bit  quiet = 1'b0;
   bit  hold_wanted = 1'b0;

   key_frequency_min_max_tracker_unit #(
      .KEYS(KEYS),
      .COUNT_BITS(COUNT_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Applies one request to the mirrored table and works out the response.
   // Counts saturate at the ceiling, a decrement of zero is flagged and
   // dropped, and keys beyond the table change nothing. The scan then walks
   // every count: ties on the maximum move to the higher index, while the
   // minimum only moves on a strictly smaller count, so the lowest index keeps
   // a tie.
   function automatic rsp_type predict_extremes(req_type r);
      rsp_type   res;
      bit        seen;
      tally_type top_n;
      tally_type low_n;
      res = '0;
      seen = 1'b0;
      top_n = '0;
      low_n = '0;
      if (r.key < KEYS) begin
         if (r.action == ACT_INC) begin
            if (tally[r.key] == {COUNT_BITS{1'b1}}) begin
               res.saturated = 1'b1;
            end else begin
               tally[r.key] = tally[r.key] + 1'b1;
            end
         end else begin
            if (tally[r.key] == '0) begin
               res.underflow = 1'b1;
            end else begin
               tally[r.key] = tally[r.key] - 1'b1;
            end
         end
      end
      for (int k = 0; k < KEYS; k++) begin
         if (tally[k] == '0) continue;
         if (!seen) begin
            seen = 1'b1;
            res.max_key = KEY_W'(k);
            res.min_key = KEY_W'(k);
            top_n = tally[k];
            low_n = tally[k];
         end else begin
            if (tally[k] >= top_n) begin
               top_n = tally[k];
               res.max_key = KEY_W'(k);
            end
            if (tally[k] < low_n) begin
               low_n = tally[k];
               res.min_key = KEY_W'(k);
            end
         end
      end
      res.any_present = seen;
      return res;
   endfunction

   function automatic probe_row_type make_row(logic act, int key, logic typed, int mx,
                                              int mn, logic any, logic uf, logic sat);
      probe_row_type p;
      p.req.action = act;
      p.req.key = KEY_W'(key);
      p.typed = typed;
      p.rsp.max_key = KEY_W'(mx);
      p.rsp.min_key = KEY_W'(mn);
      p.rsp.any_present = any;
      p.rsp.underflow = uf;
      p.rsp.saturated = sat;
      return p;
   endfunction

   // Offers one request, starting and ending at a falling edge. Valid stays
   // high from one request to the next unless an idle burst is inserted, and
   // the payload is held until the block takes it.
   task automatic send_request(req_type r, logic typed, rsp_type typed_rsp);
      rsp_type want;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      do @(posedge clock); while (!req_ready);
      want = predict_extremes(r);
      if (typed) want = typed_rsp;
      pending_reports.push_back(want);
      @(negedge clock);
   endtask

   // Compares one accepted response with the oldest expectation.
   task automatic check_response(rsp_type got);
      rsp_type want;
      if (pending_reports.size() == 0) begin
         fault_count++;
         if (fault_count <= MAX_REPORTS)
            $display("unexpected response at cycle %0d: max %0d min %0d any %0b",
                     cycle_count, got.max_key, got.min_key, got.any_present,
                     " uf %0b sat %0b", got.underflow, got.saturated);
         return;
      end
      want = pending_reports.pop_front();
      if (got.max_key !== want.max_key || got.min_key !== want.min_key ||
          got.any_present !== want.any_present || got.underflow !== want.underflow ||
          got.saturated !== want.saturated) begin
         fault_count++;
         if (fault_count <= MAX_REPORTS)
            $display("response mismatch at cycle %0d:", cycle_count,
                     " expected max %0d min %0d any %0b uf %0b sat %0b,",
                     want.max_key, want.min_key, want.any_present,
                     want.underflow, want.saturated,
                     " got max %0d min %0d any %0b uf %0b sat %0b",
                     got.max_key, got.min_key, got.any_present,
                     got.underflow, got.saturated);
      end
   endtask

   // Responses are sampled at the rising edge, before the block's own
   // registers move.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_response(rsp_data);
   end

   // Watchdog for a block that hangs or drops responses.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Response side. Ready drops in short random bursts, and once during the
   // run it stays low for a long stretch while the sender keeps offering
   // requests, so the response register and the single in-flight slot both
   // fill and req_ready has to fall.
   initial begin
      int held;
      bit hold_done;
      hold_done = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (hold_wanted && !hold_done) begin
            rsp_ready = 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++) @(negedge clock);
            hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end
         rsp_ready = 1'b1;
         @(negedge clock);
      end
   end

   // Request side: reset, a directed table, then random traffic.
   initial begin
      probe_row_type probes [$];
      req_type       r;
      int            n;
      int            pick;
      int            inc_pct;
      int            hot_keys [4];

      foreach (tally[k]) tally[k] = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Decrement on an empty table: flagged, nothing changes.
      probes.push_back(make_row(ACT_DEC, 0, 1'b1, 0, 0, 1'b0, 1'b1, 1'b0));
      // First and last key tied at one: maximum takes the high index and
      // minimum the low one.
      probes.push_back(make_row(ACT_INC, 0, 1'b1, 0, 0, 1'b1, 1'b0, 1'b0));
      probes.push_back(make_row(ACT_INC, 63, 1'b1, 63, 0, 1'b1, 1'b0, 1'b0));
      probes.push_back(make_row(ACT_INC, 63, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0));
      probes.push_back(make_row(ACT_DEC, 63, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0));
      probes.push_back(make_row(ACT_DEC, 63, 1'b1, 0, 0, 1'b1, 1'b0, 1'b0));
      // Back to an empty table, then a decrement of the last key there.
      probes.push_back(make_row(ACT_DEC, 0, 1'b1, 0, 0, 1'b0, 1'b0, 1'b0));
      probes.push_back(make_row(ACT_DEC, 63, 1'b1, 0, 0, 1'b0, 1'b1, 1'b0));
      // Three middle keys, with keys 21 and 7 tied below key 42.
      probes.push_back(make_row(ACT_INC, 42, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0));
      probes.push_back(make_row(ACT_INC, 42, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0));
      probes.push_back(make_row(ACT_INC, 21, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0));
      probes.push_back(make_row(ACT_INC, 7, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0));
      probes.push_back(make_row(ACT_DEC, 21, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0));
      probes.push_back(make_row(ACT_DEC, 42, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0));
      probes.push_back(make_row(ACT_DEC, 42, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0));
      probes.push_back(make_row(ACT_DEC, 7, 1'b0, 0, 0, 1'b0, 1'b0, 1'b0));

      foreach (probes[i]) send_request(probes[i].req, probes[i].typed, probes[i].rsp);

      // Random traffic runs in phases. Each phase has its own bias between
      // increments and decrements, so the table both fills and drains, and its
      // own handful of hot keys that collect ties.
      inc_pct = 50;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) begin
            case ($urandom_range(0, 3))
               0: inc_pct = 25;
               1: inc_pct = 50;
               2: inc_pct = 70;
               default: inc_pct = 90;
            endcase
            foreach (hot_keys[h]) hot_keys[h] = $urandom_range(0, KEYS - 1);
         end
         if (n == HOLD_AT) hold_wanted = 1'b1;
         if (n == RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 45) r.key = KEY_W'(hot_keys[$urandom_range(0, 3)]);
         else if (pick < 90) r.key = KEY_W'($urandom_range(0, KEYS - 1));
         else r.key = KEY_W'($urandom_range(0, 63));
         r.action = ($urandom_range(0, 99) < inc_pct) ? ACT_INC : ACT_DEC;
         send_request(r, 1'b0, '0);
      end
      req_valid = 1'b0;

      // Drain, then give the block time to show any response it still owes.
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (KEYS + 8) @(posedge clock);

      if (fault_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
